// ----- src/prmt_pkg.sv -----
// ----------------------------------------------------------------------------
// prmt_pkg
// Shared widths, status codes and free stack control for the pending request
// match table.
// ----------------------------------------------------------------------------
package prmt_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int SLOT_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = SLOT_W + 1;
  localparam int BLOCK_W     = 31;
  localparam int DATA_W      = 32;
  localparam int STATUS_W    = 2;
  localparam int LIMIT_W     = 5;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(TABLE_DEPTH);

  localparam logic [STATUS_W-1:0] STATUS_REQ_ACCEPTED = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_REQ_REFUSED  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_CPL_MATCHED  = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_CPL_NO_MATCH = 2'd3;

  localparam logic MODE_REQUEST    = 1'b0;
  localparam logic MODE_COMPLETION = 1'b1;

  typedef struct packed {
    logic              pop;
    logic              push;
    logic [SLOT_W-1:0] push_slot;
  } stack_cmd_t;

  typedef struct packed {
    logic              empty;
    logic [SLOT_W-1:0] top_slot;
  } stack_stat_t;

endpackage

// ----- src/pending_request_match_table.sv -----
// ----------------------------------------------------------------------------
// pending_request_match_table
// Outstanding block-read request table. A request takes a free slot; a
// completion scans the table one entry a cycle for the oldest matching block.
// Request: ST_ALLOC registers done; next start accepted in the done cycle.
// Completion: ST_SCAN makes one compare per entry, then ST_RETIRE registers done.
// Results are strobed on done for one cycle; the receiver cannot stall.
// Synchronous reset empties the table and sets the limit to the table depth.
// ----------------------------------------------------------------------------
module pending_request_match_table
  import prmt_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic                mode,
  input  logic [BLOCK_W-1:0]  block_number,
  input  logic [DATA_W-1:0]   data_value,
  input  logic                cfg_we,
  input  logic [LIMIT_W-1:0]  cfg_wdata,
  output logic                done,
  output logic [STATUS_W-1:0] status,
  output logic [SLOT_W-1:0]   slot_tag,
  output logic [DATA_W-1:0]   read_value,
  output logic [CNT_W-1:0]    pending_total
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ALLOC,
    ST_SCAN,
    ST_RETIRE
  } state_t;

  state_t             state;
  logic [LIMIT_W-1:0] request_limit;
  logic [LIMIT_W-1:0] eff_limit;
  logic [BLOCK_W-1:0] blk;
  logic [DATA_W-1:0]  value;
  logic [CNT_W-1:0]   pending_count;
  logic [SLOT_W-1:0]  idx;
  logic [SLOT_W-1:0]  best;
  logic               found;
  logic               hit;
  logic               refuse;

  logic [TABLE_DEPTH-1:0] entry_valid;
  logic [BLOCK_W-1:0]     entry_block [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] entry_older_than [TABLE_DEPTH];

  stack_cmd_t  stack_cmd;
  stack_stat_t stack_stat;

  prmt_free_stack u_free_stack (
    .clk  (clk),
    .rst  (rst),
    .cmd  (stack_cmd),
    .stat (stack_stat)
  );

  assign busy      = (state != ST_IDLE);
  assign eff_limit = (request_limit > LIMIT_W'(TABLE_DEPTH)) ? LIMIT_W'(TABLE_DEPTH)
                                                             : request_limit;
  assign refuse    = (CNT_W'(pending_count) >= CNT_W'(eff_limit)) || stack_stat.empty;
  assign hit       = entry_valid[idx] && (entry_block[idx] == blk);

  always_comb begin
    stack_cmd.pop       = (state == ST_ALLOC) && !refuse;
    stack_cmd.push      = (state == ST_RETIRE) && found;
    stack_cmd.push_slot = best;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      request_limit    <= LIMIT_RESET;
      pending_count    <= '0;
      entry_valid      <= '0;
      for (int r = 0; r < TABLE_DEPTH; r++) begin
        entry_older_than[r] <= '0;
      end
      idx              <= '0;
      best             <= '0;
      found            <= 1'b0;
      done             <= 1'b0;
      status           <= STATUS_REQ_ACCEPTED;
      slot_tag         <= '0;
      read_value       <= '0;
      pending_total    <= '0;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        request_limit <= cfg_wdata;
      end
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            blk   <= block_number;
            value <= data_value;
            idx   <= '0;
            found <= 1'b0;
            best  <= '0;
            state <= (mode == MODE_COMPLETION) ? ST_SCAN : ST_ALLOC;
          end
        end
        ST_ALLOC: begin
          done       <= 1'b1;
          read_value <= '0;
          state      <= ST_IDLE;
          if (refuse) begin
            status        <= STATUS_REQ_REFUSED;
            slot_tag      <= '0;
            pending_total <= pending_count;
          end else begin
            for (int j = 0; j < TABLE_DEPTH; j++) begin
              entry_older_than[stack_stat.top_slot][j] <=
                (SLOT_W'(j) != stack_stat.top_slot) && entry_valid[j];
            end
            for (int j = 0; j < TABLE_DEPTH; j++) begin
              if (SLOT_W'(j) != stack_stat.top_slot) begin
                entry_older_than[j][stack_stat.top_slot] <= 1'b0;
              end
            end
            entry_valid[stack_stat.top_slot] <= 1'b1;
            entry_block[stack_stat.top_slot] <= blk;
            pending_count                    <= pending_count + CNT_W'(1);
            status                           <= STATUS_REQ_ACCEPTED;
            slot_tag                         <= stack_stat.top_slot;
            pending_total                    <= pending_count + CNT_W'(1);
          end
        end
        ST_SCAN: begin
          if (hit && (!found || entry_older_than[best][idx])) begin
            best  <= idx;
            found <= 1'b1;
          end
          if (idx == SLOT_W'(TABLE_DEPTH - 1)) begin
            state <= ST_RETIRE;
          end
          idx <= idx + SLOT_W'(1);
        end
        ST_RETIRE: begin
          done  <= 1'b1;
          state <= ST_IDLE;
          if (found) begin
            entry_valid[best] <= 1'b0;
            status            <= STATUS_CPL_MATCHED;
            slot_tag          <= best;
            read_value        <= value;
            if (pending_count != '0) begin
              pending_count <= pending_count - CNT_W'(1);
              pending_total <= pending_count - CNT_W'(1);
            end else begin
              pending_total <= pending_count;
            end
          end else begin
            status        <= STATUS_CPL_NO_MATCH;
            slot_tag      <= '0;
            read_value    <= '0;
            pending_total <= pending_count;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- src/prmt_free_stack.sv -----
// ----------------------------------------------------------------------------
// prmt_free_stack
// LIFO of free slot tags; pops yield ascending slots after reset.
// ----------------------------------------------------------------------------
module prmt_free_stack
  import prmt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  stack_cmd_t  cmd,
  output stack_stat_t stat
);

  logic [SLOT_W-1:0] stack [TABLE_DEPTH];
  logic [CNT_W-1:0]  top;
  logic [CNT_W-1:0]  top_less;

  assign top_less      = top - CNT_W'(1);
  assign stat.empty    = (top == '0);
  assign stat.top_slot = stack[top_less[SLOT_W-1:0]];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < TABLE_DEPTH; k++) begin
        stack[k] <= SLOT_W'(TABLE_DEPTH - 1 - k);
      end
      top <= CNT_W'(TABLE_DEPTH);
    end else if (cmd.pop && !stat.empty) begin
      top <= top_less;
    end else if (cmd.push && (top < CNT_W'(TABLE_DEPTH))) begin
      stack[top[SLOT_W-1:0]] <= cmd.push_slot;
      top                    <= top + CNT_W'(1);
    end
  end

endmodule

// ----- test/prmt_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// prmt_checker
// Watches the command and result channels of the pending request match
// table. It keeps its own copy of the slot table, free stack and limit, works
// out the result of every accepted transaction and compares each strobed
// result, field by field, with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module prmt_checker
  import prmt_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                busy,
  input  logic                mode,
  input  logic [BLOCK_W-1:0]  block_number,
  input  logic [DATA_W-1:0]   data_value,
  input  logic                cfg_we,
  input  logic [LIMIT_W-1:0]  cfg_wdata,
  input  logic                done,
  input  logic [STATUS_W-1:0] status,
  input  logic [SLOT_W-1:0]   slot_tag,
  input  logic [DATA_W-1:0]   read_value,
  input  logic [CNT_W-1:0]    pending_total,
  output int                  fail_count,
  output int                  results_owed
);

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [DATA_W-1:0]   value;
    logic [CNT_W-1:0]    total;
  } outcome_t;

  outcome_t owed_q[$];
  int mismatches = 0;

  logic [LIMIT_W-1:0]     request_limit;
  logic                   occupied   [TABLE_DEPTH];
  logic [BLOCK_W-1:0]     held_block [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] older      [TABLE_DEPTH];
  logic [SLOT_W-1:0]      free_slots [TABLE_DEPTH];
  int                     free_top;
  int                     live_count;

  assign fail_count = mismatches;

  task automatic report(input string field, input logic [DATA_W-1:0] got,
                        input logic [DATA_W-1:0] want);
    $display("mismatch at %0t: %s got %0h, predicted %0h", $time, field, got, want);
    mismatches++;
  endtask

  function automatic void clear_table();
    request_limit = LIMIT_RESET;
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      occupied[k]   = 1'b0;
      held_block[k] = '0;
      older[k]      = '0;
      free_slots[k] = SLOT_W'(TABLE_DEPTH - 1 - k);
    end
    free_top   = TABLE_DEPTH;
    live_count = 0;
  endfunction

  function automatic outcome_t admit_request(input logic [BLOCK_W-1:0] blk);
    outcome_t res;
    int cap;
    int s;
    res = '0;
    cap = (request_limit > TABLE_DEPTH) ? TABLE_DEPTH : int'(request_limit);
    if (live_count >= cap || free_top == 0) begin
      res.status = STATUS_REQ_REFUSED;
      res.total  = CNT_W'(live_count);
      return res;
    end
    free_top--;
    s = free_slots[free_top];
    for (int j = 0; j < TABLE_DEPTH; j++) begin
      older[s][j] = (j != s) && occupied[j];
      older[j][s] = 1'b0;
    end
    occupied[s]   = 1'b1;
    held_block[s] = blk;
    live_count++;
    res.status = STATUS_REQ_ACCEPTED;
    res.slot   = SLOT_W'(s);
    res.total  = CNT_W'(live_count);
    return res;
  endfunction

  function automatic outcome_t retire_completion(input logic [BLOCK_W-1:0] blk,
                                                 input logic [DATA_W-1:0] value);
    outcome_t res;
    int best;
    res  = '0;
    best = -1;
    for (int s = 0; s < TABLE_DEPTH; s++) begin
      if (occupied[s] && held_block[s] == blk) begin
        if (best < 0) best = s;
        else if (older[best][s]) best = s;
      end
    end
    if (best < 0) begin
      res.status = STATUS_CPL_NO_MATCH;
      res.total  = CNT_W'(live_count);
      return res;
    end
    occupied[best] = 1'b0;
    if (free_top < TABLE_DEPTH) begin
      free_slots[free_top] = SLOT_W'(best);
      free_top++;
    end
    if (live_count > 0) live_count--;
    res.status = STATUS_CPL_MATCHED;
    res.slot   = SLOT_W'(best);
    res.value  = value;
    res.total  = CNT_W'(live_count);
    return res;
  endfunction

  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      clear_table();
      owed_q.delete();
      results_owed <= 0;
    end else begin
      if (cfg_we) request_limit = cfg_wdata;
      if (done) begin
        if (owed_q.size() == 0) begin
          report("result with no transaction outstanding, status", DATA_W'(status), '0);
        end else begin
          want = owed_q.pop_front();
          if (status !== want.status)
            report("status", DATA_W'(status), DATA_W'(want.status));
          if (slot_tag !== want.slot)
            report("slot_tag", DATA_W'(slot_tag), DATA_W'(want.slot));
          if (read_value !== want.value)
            report("read_value", read_value, want.value);
          if (pending_total !== want.total)
            report("pending_total", DATA_W'(pending_total), DATA_W'(want.total));
        end
      end
      if (start && !busy) begin
        if (mode == MODE_REQUEST) owed_q.push_back(admit_request(block_number));
        else owed_q.push_back(retire_completion(block_number, data_value));
      end
      results_owed <= owed_q.size();
    end
  end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives read requests and device completions into the pending request match
// table under a range of request limits, with random sender gaps, and gives
// the verdict from the checker's failure count and a stall watchdog.
// ----------------------------------------------------------------------------
module testbench;
  import prmt_pkg::*;

  localparam int STALL_LIMIT = 2000;

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  logic                mode;
  logic [BLOCK_W-1:0]  block_number;
  logic [DATA_W-1:0]   data_value;
  logic                cfg_we;
  logic [LIMIT_W-1:0]  cfg_wdata;
  logic                done;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot_tag;
  logic [DATA_W-1:0]   read_value;
  logic [CNT_W-1:0]    pending_total;

  int fail_count;
  int results_owed;
  int stalled_for = 0;

  logic [BLOCK_W-1:0] hot_blocks [8];
  int                 hot_span = 8;

  pending_request_match_table u_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .mode          (mode),
    .block_number  (block_number),
    .data_value    (data_value),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .done          (done),
    .status        (status),
    .slot_tag      (slot_tag),
    .read_value    (read_value),
    .pending_total (pending_total)
  );

  prmt_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .mode          (mode),
    .block_number  (block_number),
    .data_value    (data_value),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .done          (done),
    .status        (status),
    .slot_tag      (slot_tag),
    .read_value    (read_value),
    .pending_total (pending_total),
    .fail_count    (fail_count),
    .results_owed  (results_owed)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // abandon the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stalled_for <= 0;
    end else begin
      stalled_for <= stalled_for + 1;
      if (stalled_for == STALL_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic issue(input logic m, input logic [BLOCK_W-1:0] blk,
                       input logic [DATA_W-1:0] value);
    @(negedge clk);
    start        <= 1'b1;
    mode         <= m;
    block_number <= blk;
    data_value   <= value;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic rest(input int cycles);
    @(negedge clk);
    start <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // hold off until every outstanding transaction has returned its result
  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (results_owed != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_limit(input logic [LIMIT_W-1:0] lim);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= lim;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [BLOCK_W-1:0] pick_block();
    if ($urandom_range(9) < 7) return hot_blocks[$urandom_range(hot_span - 1)];
    return BLOCK_W'($urandom);
  endfunction

  task automatic run_phase(input logic [LIMIT_W-1:0] lim, input int count,
                           input int req_pct, input int span, input bit idle_on);
    logic m;
    set_limit(lim);
    hot_span = span;
    for (int k = 0; k < 8; k++)
      hot_blocks[k] = ($urandom_range(3) == 0) ? {BLOCK_W{k[0]}} : BLOCK_W'($urandom);
    for (int i = 0; i < count; i++) begin
      if (idle_on && $urandom_range(7) == 0) rest($urandom_range(1, 18));
      if (idle_on && $urandom_range(149) == 0) drain_results();
      m = ($urandom_range(99) < req_pct) ? MODE_REQUEST : MODE_COMPLETION;
      issue(m, pick_block(), $urandom);
    end
  endtask

  initial begin
    rst          = 1'b1;
    start        = 1'b0;
    mode         = MODE_REQUEST;
    block_number = '0;
    data_value   = '0;
    cfg_we       = 1'b0;
    cfg_wdata    = LIMIT_RESET;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // duplicates match oldest first, extremes of block and value
    issue(MODE_REQUEST,    '0,               '0);
    issue(MODE_REQUEST,    {BLOCK_W{1'b1}},  {DATA_W{1'b1}});
    issue(MODE_REQUEST,    '0,               32'h0000_0001);
    issue(MODE_COMPLETION, '0,               {DATA_W{1'b1}});
    issue(MODE_COMPLETION, '0,               '0);
    issue(MODE_COMPLETION, '0,               32'h5a5a_5a5a);
    issue(MODE_COMPLETION, {BLOCK_W{1'b1}},  32'ha5a5_a5a5);
    issue(MODE_COMPLETION, 31'h0000_1234,    32'h1234_5678);

    // zero limit refuses every request
    set_limit(5'd0);
    issue(MODE_REQUEST,    31'd7, 32'd7);
    issue(MODE_COMPLETION, 31'd7, 32'd7);

    set_limit(5'd2);
    issue(MODE_REQUEST,    31'd9, '0);
    issue(MODE_REQUEST,    31'd9, '0);
    issue(MODE_REQUEST,    31'd9, '0);
    issue(MODE_COMPLETION, 31'd9, 32'hdead_beef);
    issue(MODE_COMPLETION, 31'd9, 32'hcafe_f00d);
    issue(MODE_COMPLETION, 31'd9, 32'h0bad_0bad);

    // limit above the table depth
    set_limit(5'd31);
    issue(MODE_REQUEST,    31'd3, '0);
    issue(MODE_REQUEST,    31'd3, '0);
    issue(MODE_REQUEST,    31'd3, '0);
    issue(MODE_COMPLETION, 31'd3, 32'h1111_1111);
    issue(MODE_COMPLETION, 31'd3, 32'h2222_2222);
    issue(MODE_COMPLETION, 31'd3, 32'h3333_3333);

    run_phase(5'd16, 250, 60, 8, 1'b1);
    run_phase(5'd1,  150, 50, 4, 1'b1);
    run_phase(5'd31, 250, 70, 3, 1'b1);
    run_phase(5'd0,   60, 50, 8, 1'b1);
    run_phase(5'd4,  200, 55, 2, 1'b1);
    run_phase(5'd16, 250, 80, 6, 1'b1);
    run_phase(LIMIT_W'($urandom_range(31)), 200, 50, 5, 1'b1);
    run_phase(5'd16, 250, 50, 4, 1'b0);

    drain_results();
    repeat (TABLE_DEPTH + 4) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- pending_request_match_table.f -----
src/prmt_pkg.sv
src/prmt_free_stack.sv
src/pending_request_match_table.sv
test/prmt_checker.sv
test/testbench.sv
